// ===== rtl/core/tpi_pkg.sv =====
package tpi_pkg;

    // Coordinate width default and fixed field widths
    localparam int COORD_BITS_DEF = 16;
    localparam int FIELD_BITS     = 16;
    localparam int VTX_BITS       = 48;
    localparam int VOL_BITS       = 51;
    localparam int IN_TDATA_BITS  = 48;
    localparam int OUT_TDATA_BITS = 56;

    // Configuration port
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 64;

    localparam logic [1:0] REG_VTX_A = 2'd0;
    localparam logic [1:0] REG_VTX_B = 2'd1;
    localparam logic [1:0] REG_VTX_C = 2'd2;
    localparam logic [1:0] REG_VTX_D = 2'd3;

    // Pipeline: diff, cross product terms, cross sum, dot terms, dot sum, output
    localparam int NUM_STAGES = 6;
    localparam int NUM_FACES  = 4;

    // Edge and point vectors produced by the first stage
    localparam int NUM_VEC = 8;
    localparam logic [2:0] VEC_AB = 3'd0;
    localparam logic [2:0] VEC_AC = 3'd1;
    localparam logic [2:0] VEC_AD = 3'd2;
    localparam logic [2:0] VEC_BC = 3'd3;
    localparam logic [2:0] VEC_BD = 3'd4;
    localparam logic [2:0] VEC_BA = 3'd5;
    localparam logic [2:0] VEC_AP = 3'd6;
    localparam logic [2:0] VEC_BP = 3'd7;

    // Load enables of a two-stage section
    typedef struct packed {
        logic first;
        logic second;
    } t_ld2;

    // Face f: normal = u x v, compared against opposite vector w and point vector q
    function automatic logic [2:0] face_u(input int f);
        logic [2:0] r;
        unique case (f)
            0:       r = VEC_AB;
            1:       r = VEC_AB;
            2:       r = VEC_AC;
            default: r = VEC_BC;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] face_v(input int f);
        logic [2:0] r;
        unique case (f)
            0:       r = VEC_AC;
            1:       r = VEC_AD;
            2:       r = VEC_AD;
            default: r = VEC_BD;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] face_w(input int f);
        logic [2:0] r;
        unique case (f)
            0:       r = VEC_AD;
            1:       r = VEC_AC;
            2:       r = VEC_AB;
            default: r = VEC_BA;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] face_q(input int f);
        logic [2:0] r;
        unique case (f)
            0:       r = VEC_AP;
            1:       r = VEC_AP;
            2:       r = VEC_AP;
            default: r = VEC_BP;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/tetrahedron_point_inclusion_core.sv =====
// Point-in-tetrahedron test with exact integer arithmetic.
// Write the four vertices A..D through the APB port (64-bit data, vertex i at
// byte address 8*i, each packed z:y:x with x in the low bits); reads return
// the stored value. pready is always high. Write only while no query is in flight.
// Send query points on the slave stream: tdata carries x, y, z from bit 0 up.
// Each transaction yields one result transaction on the master stream:
// bit 0 is the inside flag (a point on a face counts as inside), bits 51:1 hold
// six times the volume, |det(B-A, C-A, D-A)|.
// Six register stages: edge differences, cross product terms, cross sums, dot
// product terms, dot sums and the sign test. Throughput is one point per cycle
// while the receiver does not stall the result stream.
// Each stage loads when it is empty or the stage after it moves, so a stalled
// receiver backs up the pipeline stage by stage; bubbles are filled and the
// slave side stays ready until every stage holds an item.
// Reset clears all stage valid bits and the vertex registers to zero.
module tetrahedron_point_inclusion_core
    import tpi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // APB configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_BITS-1:0]      paddr,
    input  logic [DATA_BITS-1:0]      pwdata,
    output logic [DATA_BITS-1:0]      prdata,
    output logic                      pready,
    // query stream
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0]  i_s_axis_tdata,   // point_x, point_y, point_z
    // result stream
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [OUT_TDATA_BITS-1:0] o_m_axis_tdata    // inside_res, six_volume, pad
);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int NORM_W = 2 * DIFF_W + 1;
    localparam int SUM_W  = NORM_W + DIFF_W + 2;
    localparam int PAD_W  = OUT_TDATA_BITS - VOL_BITS - 1;

    logic [VTX_BITS-1:0] r_vtx_a, r_vtx_b, r_vtx_c, r_vtx_d;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] ld;

    logic signed [DIFF_W-1:0] vec  [NUM_VEC][3];
    logic signed [NORM_W-1:0] norm [NUM_FACES][3];
    logic signed [DIFF_W-1:0] opp  [NUM_FACES][3];
    logic signed [DIFF_W-1:0] pnt  [NUM_FACES][3];
    logic signed [SUM_W-1:0]  sopp [NUM_FACES];
    logic signed [SUM_W-1:0]  spnt [NUM_FACES];

    t_ld2 ld_cross, ld_dot;

    logic [NUM_FACES-1:0] reject;
    logic [SUM_W-1:0]     det_abs;
    logic                 n_inside;
    logic                 r_inside;
    logic [VOL_BITS-1:0]  r_vol;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_BITS-1:ADDR_BITS-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx_a <= '0;
            r_vtx_b <= '0;
            r_vtx_c <= '0;
            r_vtx_d <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_VTX_A: r_vtx_a <= pwdata[VTX_BITS-1:0];
                REG_VTX_B: r_vtx_b <= pwdata[VTX_BITS-1:0];
                REG_VTX_C: r_vtx_c <= pwdata[VTX_BITS-1:0];
                REG_VTX_D: r_vtx_d <= pwdata[VTX_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_VTX_A: prdata = DATA_BITS'(r_vtx_a);
            REG_VTX_B: prdata = DATA_BITS'(r_vtx_b);
            REG_VTX_C: prdata = DATA_BITS'(r_vtx_c);
            REG_VTX_D: prdata = DATA_BITS'(r_vtx_d);
        endcase
    end

    // ---------------- pipeline control ----------------
    // A stage loads when empty or when the stage after it advances
    always_comb begin
        ld[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = ld[0];
    assign o_m_axis_tvalid = r_vld[NUM_STAGES-1];

    assign ld_cross.first  = ld[1];
    assign ld_cross.second = ld[2];
    assign ld_dot.first    = ld[3];
    assign ld_dot.second   = ld[4];

    // ---------------- datapath ----------------
    tpi_sub #(.COORD_BITS(COORD_BITS)) u_sub (
        .i_clk   (i_clk),
        .i_ld    (ld[0]),
        .i_vtx_a (r_vtx_a),
        .i_vtx_b (r_vtx_b),
        .i_vtx_c (r_vtx_c),
        .i_vtx_d (r_vtx_d),
        .i_point (i_s_axis_tdata),
        .o_vec   (vec)
    );

    tpi_cross #(.COORD_BITS(COORD_BITS)) u_cross (
        .i_clk  (i_clk),
        .i_ld   (ld_cross),
        .i_vec  (vec),
        .o_norm (norm),
        .o_opp  (opp),
        .o_pnt  (pnt)
    );

    tpi_dot #(.COORD_BITS(COORD_BITS)) u_dot (
        .i_clk  (i_clk),
        .i_ld   (ld_dot),
        .i_norm (norm),
        .i_opp  (opp),
        .i_pnt  (pnt),
        .o_sopp (sopp),
        .o_spnt (spnt)
    );

    // Reject a face when the opposite vertex and the point lie strictly apart
    always_comb begin
        for (int f = 0; f < NUM_FACES; f++) begin
            reject[f] = (!sopp[f][SUM_W-1] && (sopp[f] != '0) && spnt[f][SUM_W-1]) ||
                        (sopp[f][SUM_W-1] && !spnt[f][SUM_W-1] && (spnt[f] != '0));
        end
        n_inside = ~|reject;
        // The first face's opposite-vertex dot product is the edge determinant
        det_abs  = sopp[0][SUM_W-1] ? SUM_W'(-sopp[0]) : SUM_W'(sopp[0]);
    end

    always_ff @(posedge i_clk) begin
        if (ld[NUM_STAGES-1]) begin
            r_inside <= n_inside;
            r_vol    <= VOL_BITS'(det_abs);
        end
    end

    assign o_m_axis_tdata = {PAD_W'(1'b0), r_vol, r_inside};

    // ---------------- assertions ----------------
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && !ld[2] |=> r_vld[2])
        else $error("stalled stage lost its item");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NUM_STAGES-1] |-> o_s_axis_tready)
        else $error("input stalled with an empty output stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[0])
        else $error("accepted transaction did not enter the pipeline");

endmodule

// ===== rtl/core/tpi_sub.sv =====
module tpi_sub
    import tpi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DIFF_W = COORD_BITS + 1
) (
    input  logic                     i_clk,
    input  logic                     i_ld,
    input  logic [VTX_BITS-1:0]      i_vtx_a,
    input  logic [VTX_BITS-1:0]      i_vtx_b,
    input  logic [VTX_BITS-1:0]      i_vtx_c,
    input  logic [VTX_BITS-1:0]      i_vtx_d,
    input  logic [IN_TDATA_BITS-1:0] i_point,
    output logic signed [DIFF_W-1:0] o_vec [NUM_VEC][3]
);

    logic signed [COORD_BITS-1:0] a [3];
    logic signed [COORD_BITS-1:0] b [3];
    logic signed [COORD_BITS-1:0] c [3];
    logic signed [COORD_BITS-1:0] d [3];
    logic signed [COORD_BITS-1:0] p [3];
    logic signed [DIFF_W-1:0]     n_vec [NUM_VEC][3];
    logic signed [DIFF_W-1:0]     r_vec [NUM_VEC][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a[k] = $signed(i_vtx_a[k*COORD_BITS +: COORD_BITS]);
            b[k] = $signed(i_vtx_b[k*COORD_BITS +: COORD_BITS]);
            c[k] = $signed(i_vtx_c[k*COORD_BITS +: COORD_BITS]);
            d[k] = $signed(i_vtx_d[k*COORD_BITS +: COORD_BITS]);
            p[k] = $signed(i_point[k*FIELD_BITS +: COORD_BITS]);
            n_vec[VEC_AB][k] = DIFF_W'(b[k]) - DIFF_W'(a[k]);
            n_vec[VEC_AC][k] = DIFF_W'(c[k]) - DIFF_W'(a[k]);
            n_vec[VEC_AD][k] = DIFF_W'(d[k]) - DIFF_W'(a[k]);
            n_vec[VEC_BC][k] = DIFF_W'(c[k]) - DIFF_W'(b[k]);
            n_vec[VEC_BD][k] = DIFF_W'(d[k]) - DIFF_W'(b[k]);
            n_vec[VEC_BA][k] = DIFF_W'(a[k]) - DIFF_W'(b[k]);
            n_vec[VEC_AP][k] = DIFF_W'(p[k]) - DIFF_W'(a[k]);
            n_vec[VEC_BP][k] = DIFF_W'(p[k]) - DIFF_W'(b[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

// ===== rtl/core/tpi_cross.sv =====
module tpi_cross
    import tpi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DIFF_W = COORD_BITS + 1,
    localparam int PROD_W = 2 * DIFF_W,
    localparam int NORM_W = PROD_W + 1
) (
    input  logic                     i_clk,
    input  t_ld2                     i_ld,
    input  logic signed [DIFF_W-1:0] i_vec  [NUM_VEC][3],
    output logic signed [NORM_W-1:0] o_norm [NUM_FACES][3],
    output logic signed [DIFF_W-1:0] o_opp  [NUM_FACES][3],
    output logic signed [DIFF_W-1:0] o_pnt  [NUM_FACES][3]
);

    logic signed [PROD_W-1:0] r_pa   [NUM_FACES][3];
    logic signed [PROD_W-1:0] r_pb   [NUM_FACES][3];
    logic signed [DIFF_W-1:0] r_opp1 [NUM_FACES][3];
    logic signed [DIFF_W-1:0] r_pnt1 [NUM_FACES][3];
    logic signed [NORM_W-1:0] r_norm [NUM_FACES][3];
    logic signed [DIFF_W-1:0] r_opp2 [NUM_FACES][3];
    logic signed [DIFF_W-1:0] r_pnt2 [NUM_FACES][3];

    // Component k of u x v is u[k+1]*v[k+2] - u[k+2]*v[k+1]
    for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
        for (genvar k = 0; k < 3; k++) begin : g_comp
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;

            always_ff @(posedge i_clk) begin
                if (i_ld.first) begin
                    r_pa[f][k]   <= PROD_W'(i_vec[face_u(f)][K1]) *
                                    PROD_W'(i_vec[face_v(f)][K2]);
                    r_pb[f][k]   <= PROD_W'(i_vec[face_u(f)][K2]) *
                                    PROD_W'(i_vec[face_v(f)][K1]);
                    r_opp1[f][k] <= i_vec[face_w(f)][k];
                    r_pnt1[f][k] <= i_vec[face_q(f)][k];
                end
                if (i_ld.second) begin
                    r_norm[f][k] <= NORM_W'(r_pa[f][k]) - NORM_W'(r_pb[f][k]);
                    r_opp2[f][k] <= r_opp1[f][k];
                    r_pnt2[f][k] <= r_pnt1[f][k];
                end
            end
        end
    end

    assign o_norm = r_norm;
    assign o_opp  = r_opp2;
    assign o_pnt  = r_pnt2;

endmodule

// ===== rtl/core/tpi_dot.sv =====
module tpi_dot
    import tpi_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DIFF_W = COORD_BITS + 1,
    localparam int NORM_W = 2 * DIFF_W + 1,
    localparam int TERM_W = NORM_W + DIFF_W,
    localparam int SUM_W  = TERM_W + 2
) (
    input  logic                     i_clk,
    input  t_ld2                     i_ld,
    input  logic signed [NORM_W-1:0] i_norm [NUM_FACES][3],
    input  logic signed [DIFF_W-1:0] i_opp  [NUM_FACES][3],
    input  logic signed [DIFF_W-1:0] i_pnt  [NUM_FACES][3],
    output logic signed [SUM_W-1:0]  o_sopp [NUM_FACES],
    output logic signed [SUM_W-1:0]  o_spnt [NUM_FACES]
);

    logic signed [TERM_W-1:0] r_to [NUM_FACES][3];
    logic signed [TERM_W-1:0] r_tp [NUM_FACES][3];
    logic signed [SUM_W-1:0]  r_so [NUM_FACES];
    logic signed [SUM_W-1:0]  r_sp [NUM_FACES];

    always_ff @(posedge i_clk) begin
        for (int f = 0; f < NUM_FACES; f++) begin
            if (i_ld.first) begin
                for (int k = 0; k < 3; k++) begin
                    r_to[f][k] <= TERM_W'(i_norm[f][k]) * TERM_W'(i_opp[f][k]);
                    r_tp[f][k] <= TERM_W'(i_norm[f][k]) * TERM_W'(i_pnt[f][k]);
                end
            end
            if (i_ld.second) begin
                r_so[f] <= SUM_W'(r_to[f][0]) + SUM_W'(r_to[f][1]) + SUM_W'(r_to[f][2]);
                r_sp[f] <= SUM_W'(r_tp[f][0]) + SUM_W'(r_tp[f][1]) + SUM_W'(r_tp[f][2]);
            end
        end
    end

    assign o_sopp = r_so;
    assign o_spnt = r_sp;

endmodule

// ===== tb/sv/tb_tetrahedron_point_inclusion_core.sv =====
`timescale 1ns / 100ps

module tb_tetrahedron_point_inclusion_core;
    import tpi_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;

    // idling modes of the two stream sides
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SRC  = 1;
    localparam int IDLE_SNK  = 2;
    localparam int IDLE_BOTH = 3;

    // shapes of random vertex sets
    localparam int SHAPE_SMALL = 0;
    localparam int SHAPE_WIDE  = 1;
    localparam int SHAPE_FLAT  = 2;
    localparam int SHAPE_LINE  = 3;

    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } vec3_t;

    typedef struct packed {
        logic                in_tet;
        logic [VOL_BITS-1:0] vol;
    } verdict_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [ADDR_BITS-1:0]      paddr   = '0;
    logic [DATA_BITS-1:0]      pwdata  = '0;
    logic [DATA_BITS-1:0]      prdata;
    logic                      pready;

    logic                      pt_tvalid  = 1'b0;
    logic                      pt_tready;
    logic [IN_TDATA_BITS-1:0]  pt_tdata   = '0;
    logic                      res_tvalid;
    logic                      res_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] res_tdata;

    logic [VTX_BITS-1:0]      vtx_reg [4] = '{default: '0};
    logic [IN_TDATA_BITS-1:0] point_backlog [$];
    verdict_t                 verdict_q [$];
    verdict_t                 want;

    int  src_idle_pct  = 0;
    int  snk_stall_pct = 0;
    bit  pt_taken      = 1'b0;
    int  pts_issued    = 0;
    int  pts_accepted  = 0;
    int  results_seen  = 0;
    int  inside_hits   = 0;
    int  cfg_writes    = 0;
    int  errors        = 0;
    int  stall_cycles  = 0;

    tetrahedron_point_inclusion_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_s_axis_tvalid (pt_tvalid),
        .o_s_axis_tready (pt_tready),
        .i_s_axis_tdata  (pt_tdata),
        .o_m_axis_tvalid (res_tvalid),
        .i_m_axis_tready (res_tready),
        .o_m_axis_tdata  (res_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic vec3_t v3(longint x, longint y, longint z);
        vec3_t r;
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    function automatic vec3_t coords(logic [47:0] w);
        logic signed [15:0] fx, fy, fz;
        vec3_t r;
        {fz, fy, fx} = w;
        r.x = fx;
        r.y = fy;
        r.z = fz;
        return r;
    endfunction

    function automatic logic [47:0] pack_xyz(vec3_t p);
        logic [63:0] tx, ty, tz;
        tx = p.x;
        ty = p.y;
        tz = p.z;
        return {tz[15:0], ty[15:0], tx[15:0]};
    endfunction

    function automatic vec3_t vsub(vec3_t a, vec3_t b);
        return v3(a.x - b.x, a.y - b.y, a.z - b.z);
    endfunction

    function automatic vec3_t vcross(vec3_t a, vec3_t b);
        return v3(a.y * b.z - a.z * b.y, a.z * b.x - a.x * b.z, a.x * b.y - a.y * b.x);
    endfunction

    function automatic longint vdot(vec3_t a, vec3_t b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    function automatic bit strictly_opposite(longint s, longint t);
        return (s > 0 && t < 0) || (s < 0 && t > 0);
    endfunction

    // face test against the opposite vertex, plus |det(B-A, C-A, D-A)|
    function automatic verdict_t classify_point(logic [47:0] pt);
        vec3_t a, b, c, d, p, ab, ac, ad, bc, bd, ba, ap, bp, n;
        longint det;
        logic [63:0] mag;
        verdict_t v;
        a  = coords(vtx_reg[REG_VTX_A]);
        b  = coords(vtx_reg[REG_VTX_B]);
        c  = coords(vtx_reg[REG_VTX_C]);
        d  = coords(vtx_reg[REG_VTX_D]);
        p  = coords(pt);
        ab = vsub(b, a);
        ac = vsub(c, a);
        ad = vsub(d, a);
        bc = vsub(c, b);
        bd = vsub(d, b);
        ba = vsub(a, b);
        ap = vsub(p, a);
        bp = vsub(p, b);
        v.in_tet = 1'b1;
        n   = vcross(ab, ac);
        det = vdot(n, ad);
        if (strictly_opposite(det, vdot(n, ap)))
            v.in_tet = 1'b0;
        n = vcross(ab, ad);
        if (strictly_opposite(vdot(n, ac), vdot(n, ap)))
            v.in_tet = 1'b0;
        n = vcross(ac, ad);
        if (strictly_opposite(vdot(n, ab), vdot(n, ap)))
            v.in_tet = 1'b0;
        n = vcross(bc, bd);
        if (strictly_opposite(vdot(n, ba), vdot(n, bp)))
            v.in_tet = 1'b0;
        mag   = (det < 0) ? -det : det;
        v.vol = mag[VOL_BITS-1:0];
        return v;
    endfunction

    function automatic longint spread(longint centre, int unsigned half);
        return centre + longint'($urandom_range(2 * half)) - longint'(half);
    endfunction

    function automatic vec3_t wide_vec();
        logic [47:0] w;
        w[31:0]  = $urandom;
        w[47:32] = 16'($urandom_range(16'hffff));
        return coords(w);
    endfunction

    task automatic set_idling(int mode);
        case (mode)
            IDLE_NONE: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            IDLE_SRC: begin
                src_idle_pct  = 87;
                snk_stall_pct = 0;
            end
            IDLE_SNK: begin
                src_idle_pct  = 0;
                snk_stall_pct = 87;
            end
            default: begin
                src_idle_pct  = 34;
                snk_stall_pct = 34;
            end
        endcase
    endtask

    // setup cycle, then access cycle; upper data bits carry junk the block ignores
    task automatic write_vertex(logic [1:0] idx, vec3_t v);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = {16'($urandom), pack_xyz(v)};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        vtx_reg[idx] = pack_xyz(v);
        cfg_writes++;
    endtask

    task automatic write_tetra(vec3_t a, vec3_t b, vec3_t c, vec3_t d);
        write_vertex(REG_VTX_A, a);
        write_vertex(REG_VTX_B, b);
        write_vertex(REG_VTX_C, c);
        write_vertex(REG_VTX_D, d);
    endtask

    task automatic pick_vertices(int shape);
        vec3_t a, b, c, d, ctr;
        ctr = v3(spread(0, 30000), spread(0, 30000), spread(0, 30000));
        a = v3(spread(ctr.x, 200), spread(ctr.y, 200), spread(ctr.z, 200));
        b = v3(spread(ctr.x, 200), spread(ctr.y, 200), spread(ctr.z, 200));
        c = v3(spread(ctr.x, 200), spread(ctr.y, 200), spread(ctr.z, 200));
        d = v3(spread(ctr.x, 200), spread(ctr.y, 200), spread(ctr.z, 200));
        case (shape)
            SHAPE_WIDE: begin
                a = wide_vec();
                b = wide_vec();
                c = wide_vec();
                d = wide_vec();
            end
            // fourth vertex completes a parallelogram in the plane of the others
            SHAPE_FLAT: d = vsub(b, vsub(a, c));
            SHAPE_LINE: begin
                b = v3(spread(a.x, 50), spread(a.y, 50), spread(a.z, 50));
                c = vsub(b, vsub(a, b));
                d = a;
            end
            default: ;
        endcase
        write_tetra(a, b, c, d);
    endtask

    task automatic queue_point(vec3_t p);
        point_backlog.push_back(pack_xyz(p));
        pts_issued++;
    endtask

    // mostly points in the bounding box of the current vertices
    task automatic queue_random_points(int count);
        vec3_t lo, hi, v, p;
        int unsigned pick;
        lo = coords(vtx_reg[0]);
        hi = lo;
        for (int i = 1; i < 4; i++) begin
            v = coords(vtx_reg[i]);
            if (v.x < lo.x) lo.x = v.x;
            if (v.y < lo.y) lo.y = v.y;
            if (v.z < lo.z) lo.z = v.z;
            if (v.x > hi.x) hi.x = v.x;
            if (v.y > hi.y) hi.y = v.y;
            if (v.z > hi.z) hi.z = v.z;
        end
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                p = v3(lo.x - 2 + longint'($urandom_range(32'(hi.x - lo.x + 4))),
                       lo.y - 2 + longint'($urandom_range(32'(hi.y - lo.y + 4))),
                       lo.z - 2 + longint'($urandom_range(32'(hi.z - lo.z + 4))));
            else if (pick < 80)
                p = coords(vtx_reg[$urandom_range(3)]);
            else
                p = wide_vec();
            queue_point(p);
        end
    endtask

    // hold until every queued query has come back
    task automatic drain();
        while (pts_accepted != pts_issued || verdict_q.size() != 0)
            @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pt_tvalid  <= 1'b0;
            res_tready <= 1'b0;
        end else begin
            if (pt_taken || !pt_tvalid) begin
                if (point_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    pt_tvalid <= 1'b1;
                    pt_tdata  <= point_backlog.pop_front();
                end else
                    pt_tvalid <= 1'b0;
            end
            res_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        pt_taken = i_rst_n && pt_tvalid && pt_tready;
        if (pt_taken) begin
            verdict_q.push_back(classify_point(pt_tdata));
            pts_accepted++;
        end
        if (i_rst_n && res_tvalid && res_tready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                errors++;
                $display("%0t: result with no query pending, tdata %h", $time, res_tdata);
            end else begin
                want = verdict_q.pop_front();
                if (res_tdata[0] !== want.in_tet) begin
                    errors++;
                    $display("%0t: result %0d inside_res expected %0b actual %0b",
                             $time, results_seen, want.in_tet, res_tdata[0]);
                end
                if (res_tdata[VOL_BITS:1] !== want.vol) begin
                    errors++;
                    $display("%0t: result %0d six_volume expected %0d actual %0d",
                             $time, results_seen, want.vol, res_tdata[VOL_BITS:1]);
                end
                if (want.in_tet)
                    inside_hits++;
            end
        end
        if (pt_taken || (res_tvalid && res_tready) || psel)
            stall_cycles = 0;
        else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_CYCLES) begin
                $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
                $display("tb_tetrahedron_point_inclusion_core: errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        set_idling(IDLE_NONE);

        // vertices still at reset: the tetrahedron collapses to the origin
        queue_point(v3(0, 0, 0));
        queue_point(v3(32767, 32767, 32767));
        queue_point(v3(-32768, -32768, -32768));
        drain();

        // right-angle corner at the origin, legs of 100
        write_tetra(v3(0, 0, 0), v3(100, 0, 0), v3(0, 100, 0), v3(0, 0, 100));
        queue_point(v3(10, 10, 10));
        queue_point(v3(0, 0, 0));
        queue_point(v3(50, 50, 0));
        queue_point(v3(34, 33, 33));
        queue_point(v3(34, 34, 33));
        queue_point(v3(-1, 10, 10));
        queue_point(v3(10, -1, 10));
        queue_point(v3(10, 10, -1));
        queue_point(v3(32767, -32768, 0));
        queue_point(v3(-32768, 32767, -32768));
        drain();

        // full-range corners, wound for a negative determinant
        write_tetra(v3(-32768, -32768, -32768), v3(-32768, 32767, -32768),
                    v3(32767, -32768, -32768), v3(-32768, -32768, 32767));
        queue_point(v3(0, 0, -32768));
        queue_point(v3(-32768, -32768, -32768));
        queue_point(v3(32767, 32767, 32767));
        queue_point(v3(-1000, -1000, -1000));
        drain();

        // coplanar vertices: a zero opposite-vertex dot product never rejects
        write_tetra(v3(0, 0, 0), v3(10, 0, 0), v3(0, 10, 0), v3(10, 10, 0));
        queue_point(v3(5, 5, 0));
        queue_point(v3(5, 5, 7));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                1, 5:    pick_vertices(SHAPE_WIDE);
                3:       pick_vertices(SHAPE_FLAT);
                6:       pick_vertices(SHAPE_LINE);
                default: pick_vertices(SHAPE_SMALL);
            endcase
            set_idling(ph % 4);
            queue_random_points(50);
            if (ph == 4) begin
                while (pts_accepted != pts_issued)
                    @(negedge i_clk);
                drain();
            end
            queue_random_points(50);
            drain();
        end

        repeat (NUM_STAGES + 2) @(negedge i_clk);
        if (verdict_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, verdict_q.size());
        end
        $display("checked %0d query results over %0d vertex register writes",
                 results_seen, cfg_writes);
        $display("%0d points inside or on a face, %0d outside",
                 inside_hits, results_seen - inside_hits);
        if (errors == 0)
            $display("tb_tetrahedron_point_inclusion_core: clean");
        else
            $display("tb_tetrahedron_point_inclusion_core: errors");
        $finish;
    end

endmodule
